### hw/rtl/iee_pkg.sv
// package for the infix expression evaluator
// operator codes, status codes, character codes and helper functions; no dependencies
package iee_pkg;

    typedef logic [2:0] op_t;
    typedef logic [2:0] status_t;

    localparam op_t OP_NONE = 3'd0;
    localparam op_t OP_ADD  = 3'd1;
    localparam op_t OP_SUB  = 3'd2;
    localparam op_t OP_MUL  = 3'd3;
    localparam op_t OP_DIV  = 3'd4;
    localparam op_t OP_LPAR = 3'd5;

    localparam status_t ST_OK   = 3'd0;
    localparam status_t ST_DIV0 = 3'd1;
    localparam status_t ST_MAL  = 3'd2;
    localparam status_t ST_OVF  = 3'd3;
    localparam status_t ST_SAT  = 3'd4;
    localparam status_t ST_BAD  = 3'd5;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // arithmetic request to the shared unit
    typedef struct packed {
        logic       start;
        op_t        op;
    } alu_req_t;

    // precedence of an operator, zero for an opening parenthesis
    function automatic logic [1:0] prec(input op_t op);
        logic [1:0] p;
        p = 2'd0;
        if (op == OP_ADD || op == OP_SUB) p = 2'd1;
        if (op == OP_MUL || op == OP_DIV) p = 2'd2;
        return p;
    endfunction

    // merge a new error into the held one: hard errors win over saturation
    function automatic status_t merge_err(input status_t cur, input status_t nw);
        status_t r;
        r = cur;
        if (nw == ST_SAT) begin
            if (cur == ST_OK) r = ST_SAT;
        end else if (nw != ST_OK) begin
            if (cur == ST_OK || cur == ST_SAT) r = nw;
        end
        return r;
    endfunction

endpackage

### hw/rtl/iee_alu.sv
// shared arithmetic unit of the evaluator: add, subtract, multiply, divide
// multi-cycle, saturating; depends on iee_pkg
module iee_alu #(
    parameter int VW = 48,
    parameter int FB = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  iee_pkg::alu_req_t  req,
    input  logic [VW-1:0]      a,
    input  logic [VW-1:0]      b,
    output logic               done,
    output logic [VW-1:0]      res,
    output iee_pkg::status_t   err
);
    import iee_pkg::*;

    localparam int NW  = VW + FB;          // dividend width
    localparam int PW  = 2 * VW;           // product width
    localparam int CW  = $clog2(NW + 1);
    localparam int MH  = (VW + 1) / 2;     // multiplier half width

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]      state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [VW-1:0]   x_reg, x_next, y_reg, y_next;
    logic            neg_reg, neg_next;
    logic [PW-1:0]   acc_reg, acc_next;       // product or quotient magnitude
    logic [NW-1:0]   num_reg, num_next;       // dividend shift register
    logic [VW:0]     rem_reg, rem_next;
    logic            isdiv_reg, isdiv_next;
    logic            done_reg, done_next;
    logic [VW-1:0]   res_reg, res_next;
    status_t         err_reg, err_next;

    logic [VW-1:0]   vmax, xa, yb;
    logic [VW:0]     sum, rsh;
    logic [MH-1:0]   ph;
    logic [PW-1:0]   pp, rnd, mag;
    logic [VW-1:0]   lim;
    logic            ovf;

    assign vmax = {1'b0, {(VW-1){1'b1}}};
    assign xa   = a[VW-1] ? (~a + 1'b1) : a;
    assign yb   = b[VW-1] ? (~b + 1'b1) : b;
    assign done = done_reg;
    assign res  = res_reg;
    assign err  = err_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        neg_next   = neg_reg;
        acc_next   = acc_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        isdiv_next = isdiv_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        err_next   = ST_OK;
        sum        = '0;
        rsh        = '0;
        ph         = '0;
        pp         = '0;
        rnd        = '0;
        mag        = '0;
        lim        = '0;
        ovf        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req.start) begin
                    neg_next = a[VW-1] ^ b[VW-1];
                    x_next   = xa;
                    y_next   = yb;
                    acc_next = '0;
                    cnt_next = '0;
                    if (req.op == OP_ADD || req.op == OP_SUB) begin
                        sum = (req.op == OP_ADD) ? ({a[VW-1], a} + {b[VW-1], b})
                                                 : ({a[VW-1], a} - {b[VW-1], b});
                        done_next = 1'b1;
                        if (sum[VW] != sum[VW-1]) begin
                            err_next = ST_SAT;
                            res_next = sum[VW] ? ~vmax : vmax;
                        end else begin
                            res_next = sum[VW-1:0];
                        end
                    end else if (req.op == OP_MUL) begin
                        isdiv_next = 1'b0;
                        state_next = S_MUL;
                    end else if (req.op == OP_DIV) begin
                        if (b == '0) begin
                            done_next = 1'b1;
                            err_next  = ST_DIV0;
                            res_next  = '0;
                        end else begin
                            isdiv_next = 1'b1;
                            num_next   = {xa, {FB{1'b0}}};
                            rem_next   = '0;
                            state_next = S_DIV;
                        end
                    end else begin
                        done_next = 1'b1;
                        err_next  = ST_MAL;
                        res_next  = '0;
                    end
                end
            end
            S_MUL:
            begin
                // two half-width partial products, low half then high half
                ph = cnt_reg[0] ? MH'(y_reg >> MH) : y_reg[MH-1:0];
                pp = PW'(x_reg) * PW'(ph);
                acc_next = acc_reg + (cnt_reg[0] ? (pp << MH) : pp);
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[0]) state_next = S_FIN;
            end
            S_DIV:
            begin
                // restoring division, one quotient bit a cycle
                rsh = {rem_reg[VW-1:0], num_reg[NW-1]};
                num_next = num_reg << 1;
                if (rsh >= {1'b0, y_reg}) begin
                    rem_next = rsh - {1'b0, y_reg};
                    acc_next = {acc_reg[PW-2:0], 1'b1};
                end else begin
                    rem_next = rsh;
                    acc_next = {acc_reg[PW-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(NW - 1)) state_next = S_FIN;
            end
            S_FIN:
            begin
                if (isdiv_reg) begin
                    mag = acc_reg + PW'(({rem_reg, 1'b0} >= {2'b0, y_reg}) ? 1 : 0);
                end else begin
                    rnd = acc_reg + (PW'(1) << (FB - 1));
                    mag = rnd >> FB;
                end
                lim = neg_reg ? (vmax + 1'b1) : vmax;
                ovf = (mag[PW-1:VW] != '0) || (mag[VW-1:0] > lim);
                if (ovf) begin
                    err_next = ST_SAT;
                    mag      = PW'(lim);
                end
                res_next   = neg_reg ? (~mag[VW-1:0] + 1'b1) : mag[VW-1:0];
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
            err_reg   <= ST_OK;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        neg_reg   <= neg_next;
        acc_reg   <= acc_next;
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        isdiv_reg <= isdiv_next;
        res_reg   <= res_next;
    end

endmodule

### hw/rtl/infix_expression_evaluator_unit.sv
// top level of the infix expression evaluator (shunting-yard)
// holds the two stack memories and the character sequencer; uses iee_pkg, iee_alu
//
// usage:
//  - input channel (valid/ready): one ascii character per beat, last marks
//    the final character of an expression
//  - output channel (valid/ready): one beat per expression, value (signed
//    fixed point, FRAC_BITS fraction bits) and status
//  - digits and dots are taken in the character state; other characters go to
//    dispatch; operators and closing parentheses may trigger reductions
//  - a reduction pops the operator and reads operand b, then reads operand a,
//    runs the shared arithmetic unit and writes the result back
//  - closing a number at a delimiter pushes it on the value stack, after a pass
//    through the fraction divider when it has fraction digits
//  - the last character drains the operator stack, then the result beat is
//    held in the output register until taken; the next expression is accepted
//    meanwhile and its result waits in the sequencer while the register is full
//  - an output stall holds in_ready low only once a second result is waiting
//  - reset clears counters, number flags and the error code; the stack memories
//    are not cleared, entries above the fill counts are never used
module infix_expression_evaluator_unit #(
    parameter int STACK_DEPTH     = 16,
    parameter int FRAC_BITS       = 16,
    parameter int VALUE_WIDTH     = 48,
    parameter int MAX_FRAC_DIGITS = 6
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [7:0]              char_code,
    input  logic                    last,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [VALUE_WIDTH-1:0]  value,
    output iee_pkg::status_t        status
);
    import iee_pkg::*;

    localparam int VW  = VALUE_WIDTH;
    localparam int FB  = FRAC_BITS;
    localparam int AW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNW = $clog2(STACK_DEPTH + 1);
    localparam int FDW = $clog2(MAX_FRAC_DIGITS + 1);
    localparam int DECW = 4 * MAX_FRAC_DIGITS;     // frac_dec < 10^digits
    localparam int FNW = DECW + FB + 1;            // fraction dividend width
    localparam int DVW = 4 * MAX_FRAC_DIGITS;      // divisor width
    localparam int FCW = $clog2(FNW + 1);

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CHAR  = 4'd1;
    localparam logic [3:0] S_FDIV  = 4'd2;
    localparam logic [3:0] S_PUSHN = 4'd3;
    localparam logic [3:0] S_DISP  = 4'd4;
    localparam logic [3:0] S_TOPOP = 4'd5;
    localparam logic [3:0] S_RDV   = 4'd6;
    localparam logic [3:0] S_RDV2  = 4'd7;
    localparam logic [3:0] S_ALU   = 4'd8;
    localparam logic [3:0] S_WAIT  = 4'd9;
    localparam logic [3:0] S_FINV  = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    // what the sequencer does after a number is pushed
    localparam logic [1:0] K_CH  = 2'd0;   // delimiter char processing
    localparam logic [1:0] K_END = 2'd1;   // end of expression drain

    // stack memories, synchronous read
    logic [VW-1:0] vmem [STACK_DEPTH];
    logic [2:0]    omem [STACK_DEPTH];
    logic [VW-1:0] vrd_reg;
    logic [2:0]    ord_reg;
    logic          vwe, owe;
    logic [AW-1:0] vwa, vra, owa, ora;
    logic [VW-1:0] vwd;
    op_t           owd;

    logic [3:0]     state_reg, state_next;
    logic [7:0]     ch_reg, ch_next;
    logic           last_reg, last_next;
    logic [1:0]     kind_reg, kind_next;
    logic [CNW-1:0] vcnt_reg, vcnt_next, ocnt_reg, ocnt_next;
    logic [VW-1:0]  nacc_reg, nacc_next;
    logic [DECW-1:0] fdec_reg, fdec_next;
    logic [FDW-1:0] fdig_reg, fdig_next;
    logic           innum_reg, innum_next, dot_reg, dot_next, dot2_reg, dot2_next;
    status_t        err_reg, err_next;
    op_t            pend_reg, pend_next;     // operator waiting for push
    logic           rpar_reg, rpar_next;     // closing parenthesis in progress
    logic [VW-1:0]  bval_reg, bval_next;
    logic [FNW-1:0] fnum_reg, fnum_next;
    logic [DVW:0]   frem_reg, frem_next;
    logic [FB+DECW:0] fq_reg, fq_next;
    logic [DVW-1:0] fden_reg, fden_next;
    logic [FCW-1:0] fcnt_reg, fcnt_next;
    logic           ov_reg, ov_next;
    logic [VW-1:0]  oval_reg, oval_next;
    status_t        ost_reg, ost_next;

    alu_req_t       areq;
    logic           adone;
    logic [VW-1:0]  ares;
    status_t        aerr;

    logic [VW-1:0]  vmax, dv, fv, nx10;
    logic [VW+4:0]  prod10;
    logic           hard, isdig, isws;
    logic [3:0]     dig;
    op_t            chop;
    logic [DVW:0]   frsh;
    logic [DVW-1:0] pw10;
    logic [VW:0]    fsum;

    assign vmax = {1'b0, {(VW-1){1'b1}}};
    assign hard = (err_reg != ST_OK) && (err_reg != ST_SAT);

    iee_alu #(.VW(VW), .FB(FB)) u_alu (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (areq),
        .a    (vrd_reg),
        .b    (bval_reg),
        .done (adone),
        .res  (ares),
        .err  (aerr)
    );

    always_ff @(posedge clk)
    begin
        if (vwe) vmem[vwa] <= vwd;
        if (owe) omem[owa] <= owd;
        vrd_reg <= vmem[vra];
        ord_reg <= omem[ora];
    end

    // power of ten for the fraction divisor, by digit count
    always_comb
    begin
        pw10 = DVW'(1);
        for (int i = 0; i < MAX_FRAC_DIGITS; i++)
            if (FDW'(i) < fdig_reg) pw10 = DVW'(pw10 * 4'd10);
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign value     = oval_reg;
    assign status    = ost_reg;

    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        last_next  = last_reg;
        kind_next  = kind_reg;
        vcnt_next  = vcnt_reg;
        ocnt_next  = ocnt_reg;
        nacc_next  = nacc_reg;
        fdec_next  = fdec_reg;
        fdig_next  = fdig_reg;
        innum_next = innum_reg;
        dot_next   = dot_reg;
        dot2_next  = dot2_reg;
        err_next   = err_reg;
        pend_next  = pend_reg;
        rpar_next  = rpar_reg;
        bval_next  = bval_reg;
        fnum_next  = fnum_reg;
        frem_next  = frem_reg;
        fq_next    = fq_reg;
        fden_next  = fden_reg;
        fcnt_next  = fcnt_reg;
        ov_next    = ov_reg;
        oval_next  = oval_reg;
        ost_next   = ost_reg;
        vwe = 1'b0; vwa = '0; vwd = '0; vra = '0;
        owe = 1'b0; owa = '0; owd = OP_NONE; ora = '0;
        areq.start = 1'b0;
        areq.op    = OP_NONE;
        isdig  = (ch_reg >= CH_ZERO) && (ch_reg <= CH_NINE);
        isws   = (ch_reg == CH_SPACE) || ((ch_reg >= 8'd9) && (ch_reg <= 8'd13));
        dig    = 4'(ch_reg - CH_ZERO);
        dv     = VW'(dig) << FB;
        prod10 = (VW+5)'(nacc_reg) * 5'd10;
        nx10   = '0;
        frsh   = '0;
        fv     = '0;
        fsum   = '0;
        chop   = OP_NONE;
        case (ch_reg)
            CH_PLUS:  chop = OP_ADD;
            CH_MINUS: chop = OP_SUB;
            CH_STAR:  chop = OP_MUL;
            CH_SLASH: chop = OP_DIV;
            default:  chop = OP_NONE;
        endcase

        if (ov_reg && out_ready) ov_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid) begin
                    ch_next    = char_code;
                    last_next  = last;
                    state_next = S_CHAR;
                end
            end
            S_CHAR:
            begin
                // top of operator stack read ahead for later dispatch
                ora = AW'(ocnt_reg - 1'b1);
                if (hard) begin
                    state_next = last_reg ? S_FINV : S_IDLE;
                end else if (isdig) begin
                    if (!innum_reg) begin
                        innum_next = 1'b1; dot_next = 1'b0; dot2_next = 1'b0;
                        fdec_next = '0; fdig_next = '0; nacc_next = '0;
                    end
                    if (innum_reg && dot2_reg) begin
                        // ignored digit
                    end else if (innum_reg && dot_reg) begin
                        if (fdig_reg < FDW'(MAX_FRAC_DIGITS)) begin
                            fdec_next = DECW'(fdec_reg * 4'd10 + DECW'(dig));
                            fdig_next = fdig_reg + 1'b1;
                        end
                    end else begin
                        nx10 = innum_reg ? nacc_reg : '0;
                        prod10 = (VW+5)'(nx10) * 5'd10 + (VW+5)'(dv);
                        if (prod10 > (VW+5)'(vmax)) begin
                            err_next  = merge_err(err_reg, ST_SAT);
                            nacc_next = vmax;
                        end else begin
                            nacc_next = prod10[VW-1:0];
                        end
                    end
                    state_next = last_reg ? S_DISP : S_IDLE;
                    kind_next  = K_END;
                end else if (ch_reg == CH_DOT) begin
                    if (!innum_reg) begin
                        innum_next = 1'b1; dot_next = 1'b1; dot2_next = 1'b0;
                        fdec_next = '0; fdig_next = '0; nacc_next = '0;
                    end else if (dot_reg) begin
                        dot2_next = 1'b1;
                    end else begin
                        dot_next = 1'b1;
                    end
                    state_next = last_reg ? S_DISP : S_IDLE;
                    kind_next  = K_END;
                end else begin
                    kind_next = K_CH;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                // close a pending number first
                ora = AW'(ocnt_reg - 1'b1);
                if (innum_reg && !hard) begin
                    innum_next = 1'b0;
                    fnum_next  = FNW'({fdec_reg, {FB{1'b0}}}) + FNW'(pw10 >> 1);
                    fden_next  = pw10;
                    frem_next  = '0;
                    fq_next    = '0;
                    fcnt_next  = '0;
                    state_next = (fdig_reg != '0) ? S_FDIV : S_PUSHN;
                end else if (hard) begin
                    state_next = last_reg ? S_FINV : S_IDLE;
                end else if (kind_reg == K_CH) begin
                    kind_next = K_END;
                    if (isws) begin
                        state_next = last_reg ? S_DISP : S_IDLE;
                    end else if (ch_reg == CH_LPAR) begin
                        if (ocnt_reg >= CNW'(STACK_DEPTH)) begin
                            err_next = merge_err(err_reg, ST_OVF);
                        end else begin
                            owe = 1'b1; owa = AW'(ocnt_reg); owd = OP_LPAR;
                            ocnt_next = ocnt_reg + 1'b1;
                        end
                        // the drain needs the new top, so read it again first
                        state_next = last_reg ? S_RDV2 : S_IDLE;
                    end else if (ch_reg == CH_RPAR) begin
                        rpar_next  = 1'b1;
                        pend_next  = OP_NONE;
                        state_next = S_TOPOP;
                    end else if (chop != OP_NONE) begin
                        pend_next  = chop;
                        rpar_next  = 1'b0;
                        state_next = S_TOPOP;
                    end else begin
                        err_next   = merge_err(err_reg, ST_BAD);
                        state_next = last_reg ? S_FINV : S_IDLE;
                    end
                end else begin
                    // end of expression: drain
                    pend_next  = OP_NONE;
                    rpar_next  = 1'b0;
                    state_next = last_reg ? S_TOPOP : S_IDLE;
                end
            end
            S_FDIV:
            begin
                // fraction rounding divide, one bit a cycle
                frsh = {frem_reg[DVW-1:0], fnum_reg[FNW-1]};
                fnum_next = fnum_reg << 1;
                if (frsh >= {1'b0, fden_reg}) begin
                    frem_next = frsh - {1'b0, fden_reg};
                    fq_next   = {fq_reg[FB+DECW-1:0], 1'b1};
                end else begin
                    frem_next = frsh;
                    fq_next   = {fq_reg[FB+DECW-1:0], 1'b0};
                end
                fcnt_next = fcnt_reg + 1'b1;
                if (fcnt_reg == FCW'(FNW - 1)) state_next = S_PUSHN;
            end
            S_PUSHN:
            begin
                fv = (fdig_reg != '0) ? VW'(fq_reg) : '0;
                fsum = {1'b0, nacc_reg} + {1'b0, fv};
                if (fsum > {1'b0, vmax}) begin
                    err_next = merge_err(err_reg, ST_SAT);
                    fsum = {1'b0, vmax};
                end
                if (vcnt_reg >= CNW'(STACK_DEPTH)) begin
                    err_next = merge_err(err_reg, ST_OVF);
                end else begin
                    vwe = 1'b1; vwa = AW'(vcnt_reg); vwd = fsum[VW-1:0];
                    vcnt_next = vcnt_reg + 1'b1;
                end
                ora = AW'(ocnt_reg - 1'b1);
                state_next = S_DISP;
            end
            S_TOPOP:
            begin
                // ord_reg holds the top operator here
                ora = AW'(ocnt_reg - 1'b1);
                if (hard) begin
                    state_next = last_reg ? S_FINV : S_IDLE;
                end else if (rpar_reg) begin
                    if (ocnt_reg == '0) begin
                        err_next   = merge_err(err_reg, ST_MAL);
                        rpar_next  = 1'b0;
                        state_next = last_reg ? S_TOPOP : S_IDLE;
                    end else if (ord_reg == OP_LPAR) begin
                        ocnt_next  = ocnt_reg - 1'b1;
                        rpar_next  = 1'b0;
                        state_next = S_RDV2;
                    end else begin
                        state_next = S_RDV;
                    end
                end else if (pend_reg != OP_NONE) begin
                    if (ocnt_reg != '0 && ord_reg != OP_LPAR &&
                        prec(ord_reg) >= prec(pend_reg)) begin
                        state_next = S_RDV;
                    end else begin
                        if (ocnt_reg >= CNW'(STACK_DEPTH)) begin
                            err_next = merge_err(err_reg, ST_OVF);
                        end else begin
                            owe = 1'b1; owa = AW'(ocnt_reg); owd = pend_reg;
                            ocnt_next = ocnt_reg + 1'b1;
                        end
                        pend_next  = OP_NONE;
                        state_next = last_reg ? S_RDV2 : S_IDLE;
                    end
                end else if (last_reg) begin
                    if (ocnt_reg == '0) begin
                        state_next = S_FINV;
                    end else if (ord_reg == OP_LPAR) begin
                        err_next   = merge_err(err_reg, ST_MAL);
                        ocnt_next  = ocnt_reg - 1'b1;
                        state_next = S_FINV;
                    end else begin
                        state_next = S_RDV;
                    end
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_RDV2:
            begin
                // refresh the top-of-stack read after a pop or push
                ora = AW'(ocnt_reg - 1'b1);
                if (last_reg || rpar_reg || pend_reg != OP_NONE) begin
                    state_next = S_TOPOP;
                end else begin
                    state_next = S_IDLE;
                end
            end
            S_RDV:
            begin
                // pop the operator, read operand b
                ocnt_next = ocnt_reg - 1'b1;
                pend_next = pend_reg;
                ch_next   = ch_reg;
                if (vcnt_reg < CNW'(2)) begin
                    err_next   = merge_err(err_reg, ST_MAL);
                    state_next = last_reg ? S_FINV : S_IDLE;
                end else begin
                    vra = AW'(vcnt_reg - 1'b1);
                    state_next = S_ALU;
                end
                bval_next = '0;
                // keep the operator code from ord_reg: store it in the fden register, free here
                fden_next = DVW'(ord_reg);
            end
            S_ALU:
            begin
                bval_next  = vrd_reg;
                vra        = AW'(vcnt_reg - 2'd2);
                state_next = S_WAIT;
                fcnt_next  = '0;
            end
            S_WAIT:
            begin
                if (fcnt_reg == '0) begin
                    areq.start = 1'b1;
                    areq.op    = op_t'(fden_reg[2:0]);
                    fcnt_next  = FCW'(1);
                end
                if (adone) begin
                    err_next  = merge_err(err_reg, aerr);
                    vwe = 1'b1; vwa = AW'(vcnt_reg - 2'd2); vwd = ares;
                    vcnt_next = vcnt_reg - 1'b1;
                    ora = AW'(ocnt_reg - 1'b1);
                    state_next = S_RDV2;
                end
            end
            S_FINV:
            begin
                vra = '0;
                if (!hard && vcnt_reg != CNW'(1)) err_next = merge_err(err_reg, ST_MAL);
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ov_reg) begin
                    ov_next   = 1'b1;
                    ost_next  = err_reg;
                    oval_next = hard ? '0 : vrd_reg;
                    vcnt_next = '0; ocnt_next = '0;
                    innum_next = 1'b0; dot_next = 1'b0; dot2_next = 1'b0;
                    nacc_next = '0; fdec_next = '0; fdig_next = '0;
                    err_next  = ST_OK;
                    pend_next = OP_NONE; rpar_next = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            vcnt_reg  <= '0;
            ocnt_reg  <= '0;
            innum_reg <= 1'b0;
            dot_reg   <= 1'b0;
            dot2_reg  <= 1'b0;
            nacc_reg  <= '0;
            fdec_reg  <= '0;
            fdig_reg  <= '0;
            err_reg   <= ST_OK;
            pend_reg  <= OP_NONE;
            rpar_reg  <= 1'b0;
            ov_reg    <= 1'b0;
            kind_reg  <= K_CH;
        end else begin
            state_reg <= state_next;
            vcnt_reg  <= vcnt_next;
            ocnt_reg  <= ocnt_next;
            innum_reg <= innum_next;
            dot_reg   <= dot_next;
            dot2_reg  <= dot2_next;
            nacc_reg  <= nacc_next;
            fdec_reg  <= fdec_next;
            fdig_reg  <= fdig_next;
            err_reg   <= err_next;
            pend_reg  <= pend_next;
            rpar_reg  <= rpar_next;
            ov_reg    <= ov_next;
            kind_reg  <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg   <= ch_next;
        last_reg <= last_next;
        bval_reg <= bval_next;
        fnum_reg <= fnum_next;
        frem_reg <= frem_next;
        fq_reg   <= fq_next;
        fden_reg <= fden_next;
        fcnt_reg <= fcnt_next;
        oval_reg <= oval_next;
        ost_reg  <= ost_next;
    end

    // stack fill counts never pass the depth
    a_vcnt: assert property (@(posedge clk) disable iff (!rst_n)
        vcnt_reg <= CNW'(STACK_DEPTH)) else $error("value count overrun");
    a_ocnt: assert property (@(posedge clk) disable iff (!rst_n)
        ocnt_reg <= CNW'(STACK_DEPTH)) else $error("operator count overrun");
    // no input taken while a result is pending in the sequencer
    a_noacc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |-> !in_ready) else $error("accept during output");
    // a hard error result carries zero
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != ST_OK && status != ST_SAT) |-> (value == '0))
        else $error("error result not zero");

endmodule

### tb/infix_expression_evaluator_unit_tb.sv
// testbench for the infix expression evaluator: streams character beats, predicts
// each expression's value and status in a behavioral model; uses iee_pkg and the rtl
`timescale 1ns / 1ps

module infix_expression_evaluator_unit_tb;
    import iee_pkg::*;

    localparam int DEPTH = 16;
    localparam int FRACB = 16;
    localparam int VW = 48;
    localparam int MAXFD = 6;
    localparam longint VMAX = (64'sd1 <<< (VW - 1)) - 1;
    localparam longint VMIN = -VMAX - 1;
    localparam longint LIMIT = 4000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [7:0] char_code = 8'd0;
    logic last = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [VW-1:0] value;
    status_t status;

    infix_expression_evaluator_unit i_dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .char_code(char_code), .last(last), .out_valid(out_valid),
        .out_ready(out_ready), .value(value), .status(status)
    );

    always #6 clk = ~clk;

    typedef struct packed {
        logic [7:0] ch;
        logic       lst;
    } char_beat_t;

    typedef struct packed {
        logic [VW-1:0] val;
        status_t       st;
    } eval_result_t;

    char_beat_t   char_queue[$];
    eval_result_t result_queue[$];
    int  fail_count = 0;
    int  send_idle_pct = 21;
    int  recv_idle_pct = 74;
    bit  hold_send = 1'b0;
    longint cycle_count = 0;

    // ---------------- predictor state ----------------
    longint  vstk[DEPTH];
    op_t     ostk[DEPTH];
    int      vcnt, ocnt;
    longint  int_acc, frac_acc;
    int      fdig;
    bit      in_num, dot1, dot2;
    status_t err;

    function automatic void clear_eval();
        vcnt = 0; ocnt = 0; int_acc = 0; frac_acc = 0; fdig = 0;
        in_num = 0; dot1 = 0; dot2 = 0; err = ST_OK;
    endfunction

    function automatic void flag(status_t s);
        if (s == ST_SAT) begin
            if (err == ST_OK) err = ST_SAT;
        end else if (err == ST_OK || err == ST_SAT) err = s;
    endfunction

    function automatic bit hard();
        return err != ST_OK && err != ST_SAT;
    endfunction

    // magnitude in 128 bits to saturated signed value
    function automatic longint clamp_mag(logic [127:0] m, bit neg);
        logic [127:0] lim;
        lim = neg ? 128'(VMAX) + 1 : 128'(VMAX);
        if (m > lim) begin
            flag(ST_SAT);
            m = lim;
        end
        return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function automatic longint fixed_mul(longint a, longint b);
        logic [127:0] p;
        p = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
        p = (p + (128'd1 << (FRACB - 1))) >> FRACB;
        return clamp_mag(p, (a < 0) != (b < 0));
    endfunction

    function automatic longint fixed_div(longint a, longint b);
        logic [127:0] n, d, q, r;
        if (b == 0) begin
            flag(ST_DIV0);
            return 0;
        end
        n = 128'(a < 0 ? -a : a) << FRACB;
        d = 128'(b < 0 ? -b : b);
        q = n / d;
        r = n % d;
        if (r * 2 >= d) q = q + 1;
        return clamp_mag(q, (a < 0) != (b < 0));
    endfunction

    function automatic int op_rank(op_t o);
        if (o == OP_ADD || o == OP_SUB) return 1;
        if (o == OP_MUL || o == OP_DIV) return 2;
        return 0;
    endfunction

    function automatic void push_value(longint v);
        if (vcnt >= DEPTH) flag(ST_OVF);
        else begin
            vstk[vcnt] = v;
            vcnt++;
        end
    endfunction

    function automatic void push_oper(op_t o);
        if (ocnt >= DEPTH) flag(ST_OVF);
        else begin
            ostk[ocnt] = o;
            ocnt++;
        end
    endfunction

    function automatic void apply_top();
        op_t o;
        longint a, b, r;
        if (ocnt == 0) return;
        ocnt--;
        o = ostk[ocnt];
        if (vcnt < 2) begin
            flag(ST_MAL);
            return;
        end
        b = vstk[vcnt-1];
        a = vstk[vcnt-2];
        r = 0;
        case (o)
            OP_ADD: begin
                r = a + b;
                if (r > VMAX) begin flag(ST_SAT); r = VMAX; end
                if (r < VMIN) begin flag(ST_SAT); r = VMIN; end
            end
            OP_SUB: begin
                r = a - b;
                if (r > VMAX) begin flag(ST_SAT); r = VMAX; end
                if (r < VMIN) begin flag(ST_SAT); r = VMIN; end
            end
            OP_MUL: r = fixed_mul(a, b);
            OP_DIV: r = fixed_div(a, b);
            default: flag(ST_MAL);
        endcase
        vcnt--;
        vstk[vcnt-1] = r;
    endfunction

    function automatic void close_number();
        longint p, f, v;
        if (!in_num) return;
        in_num = 0;
        f = 0;
        if (fdig > 0) begin
            p = 1;
            for (int i = 0; i < fdig; i++) p = p * 10;
            f = ((frac_acc <<< FRACB) + p / 2) / p;
        end
        v = int_acc;
        if (f > VMAX - v) begin
            flag(ST_SAT);
            v = VMAX;
        end else v = v + f;
        push_value(v);
    endfunction

    function automatic void open_number();
        if (in_num) return;
        in_num = 1; dot1 = 0; dot2 = 0; int_acc = 0; frac_acc = 0; fdig = 0;
    endfunction

    function automatic void eat_char(logic [7:0] c);
        op_t o;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            longint dv;
            dv = longint'(c - CH_ZERO) <<< FRACB;
            open_number();
            if (dot2) return;
            if (dot1) begin
                if (fdig < MAXFD) begin
                    frac_acc = frac_acc * 10 + (c - CH_ZERO);
                    fdig++;
                end
            end else if (int_acc > (VMAX - dv) / 10) begin
                flag(ST_SAT);
                int_acc = VMAX;
            end else int_acc = int_acc * 10 + dv;
            return;
        end
        if (c == CH_DOT) begin
            open_number();
            if (dot1) dot2 = 1; else dot1 = 1;
            return;
        end
        close_number();
        if (c == CH_SPACE || (c >= 8'd9 && c <= 8'd13)) return;
        if (c == CH_LPAR) begin
            push_oper(OP_LPAR);
            return;
        end
        if (c == CH_RPAR) begin
            while (ocnt > 0 && ostk[ocnt-1] != OP_LPAR) apply_top();
            if (ocnt == 0) flag(ST_MAL); else ocnt--;
            return;
        end
        case (c)
            CH_PLUS:  o = OP_ADD;
            CH_MINUS: o = OP_SUB;
            CH_STAR:  o = OP_MUL;
            CH_SLASH: o = OP_DIV;
            default:  o = OP_NONE;
        endcase
        if (o == OP_NONE) begin
            flag(ST_BAD);
            return;
        end
        while (ocnt > 0 && ostk[ocnt-1] != OP_LPAR && op_rank(ostk[ocnt-1]) >= op_rank(o))
            apply_top();
        push_oper(o);
    endfunction

    // predict for one accepted beat; pushes an expectation on the last one
    function automatic void predict_beat(char_beat_t b);
        eval_result_t res;
        if (!hard()) eat_char(b.ch);
        if (!b.lst) return;
        if (!hard()) close_number();
        while (!hard() && ocnt > 0) begin
            if (ostk[ocnt-1] == OP_LPAR) begin
                flag(ST_MAL);
                ocnt--;
            end else apply_top();
        end
        if (!hard() && vcnt != 1) flag(ST_MAL);
        res.val = hard() ? '0 : VW'(vstk[0]);
        res.st = err;
        result_queue.push_back(res);
        clear_eval();
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
                 cycle_count);
        fail_count++;
    endtask

    // ---------------- driver ----------------
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) predict_beat('{char_code, last});
            if (!in_valid || in_ready) begin
                if (char_queue.size() > 0 && !hold_send
                    && $urandom_range(99) >= send_idle_pct) begin
                    in_valid  <= 1'b1;
                    char_code <= char_queue[0].ch;
                    last      <= char_queue[0].lst;
                    void'(char_queue.pop_front());
                end else in_valid <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge clk) begin
        if (rst_n) begin
            cycle_count <= cycle_count + 1;
            if (out_valid && out_ready) begin
                if (result_queue.size() == 0) report_mismatch("unexpected beat", value, 0);
                else begin
                    if (value !== result_queue[0].val)
                        report_mismatch("value", value, result_queue[0].val);
                    if (status !== result_queue[0].st)
                        report_mismatch("status", status, result_queue[0].st);
                    void'(result_queue.pop_front());
                end
            end
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ---------------- stimulus ----------------
    task automatic add_expr(string s);
        for (int i = 0; i < s.len(); i++) char_queue.push_back('{s[i], i == s.len() - 1});
    endtask

    function automatic string rand_num();
        string s;
        int n;
        s = "";
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) s = {s, string'(8'(CH_ZERO + $urandom_range(9)))};
        if ($urandom_range(2) == 0) begin
            s = {s, "."};
            n = $urandom_range(0, 8);
            for (int i = 0; i < n; i++) s = {s, string'(8'(CH_ZERO + $urandom_range(9)))};
        end
        return s;
    endfunction

    function automatic string rand_expr(int lvl);
        string s, ops;
        int n;
        ops = "+-*/";
        s = (lvl < 3 && $urandom_range(3) == 0) ? {"(", rand_expr(lvl + 1), ")"} : rand_num();
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(3) == 0) s = {s, " "};
            s = {s, string'(ops[$urandom_range(3)])};
            s = {s, (lvl < 3 && $urandom_range(3) == 0)
                    ? {"(", rand_expr(lvl + 1), ")"} : rand_num()};
        end
        return s;
    endfunction

    task automatic random_phase(int items);
        string s;
        int count;
        count = 0;
        while (count < items) begin
            if ($urandom_range(9) < 8) s = rand_expr(0);
            else begin
                s = "";
                for (int i = $urandom_range(1, 6); i > 0; i--)
                    s = {s, string'(8'($urandom_range(255)))};
            end
            add_expr(s);
            count += s.len();
        end
    endtask

    task automatic wait_drained();
        while (char_queue.size() > 0 || in_valid || result_queue.size() > 0)
            @(posedge clk);
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        // directed: every operation, extremes, error cases
        add_expr("1+2*3");
        add_expr("(7-2)/4");
        add_expr("1/0");
        add_expr("2+");
        add_expr("(3");
        add_expr(")");
        add_expr(" ");
        add_expr("3#");
        add_expr("1.2.99");
        add_expr(".");
        add_expr("0.9999995");
        add_expr("99999999999*99999");
        add_expr("2147483647*2147483647");
        add_expr("1-99999999999-99999999999");
        add_expr("((((((((((((((((1))))))))))))))))");
        add_expr("1+1+1+1+1+1+1+1+1+1+1+1+1+1+1+1+1+1");
        add_expr("1*(1*(1*(1*(1*(1*(1*(1*(1*(1*(1*(1*(1*(1*(1*(1*(1*2)))))))))))))))))");
        char_queue.push_back('{8'hFF, 1'b0});
        char_queue.push_back('{8'h09, 1'b1});
        random_phase(450);
        // hold off until all results are back
        wait_drained();
        hold_send = 1'b1;
        repeat (20) @(posedge clk);
        hold_send = 1'b0;
        send_idle_pct = 74;
        recv_idle_pct = 21;
        random_phase(450);
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(450);
        wait_drained();
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        wait (cycle_count >= LIMIT);
        $display("status: fail");
        $finish;
    end

endmodule
